// File: rtl/sioc_pkg.sv
// ----------------------------------------------------------------------------
// Sorted interval overlap count package
// Shared constants, codes and types for the overlap count block.
// ----------------------------------------------------------------------------
`default_nettype none

package sioc_pkg;

	// Default sizes of the peak table and of the fields.
	localparam int DEF_MAX_PEAKS  = 4096;
	localparam int DEF_COORD_BITS = 32;
	localparam int DEF_CHROM_BITS = 10;

	// Fixed field widths.
	localparam int SLOT_W  = 12;
	localparam int POS_W   = 13;
	localparam int SCORE_W = 32;
	localparam int CNT_W   = 13;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 3;

	// Result beat layout: position, then score, padded to whole bytes.
	localparam int OUT_BITS = POS_W + SCORE_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Configuration port.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_PEAK_COUNT = 1'b0;

	// Operation codes carried in the input tuser.
	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_READ    = 2'd1,
		OP_QUERY   = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	// Result status codes carried in the output tuser.
	typedef enum logic [STAT_W-1:0] {
		STAT_LOADED  = 3'd0,
		STAT_COUNTED = 3'd1,
		STAT_MISSED  = 3'd2,
		STAT_DONE    = 3'd3,
		STAT_SCORE   = 3'd4
	} status_t;

	// One result item.
	typedef struct packed {
		status_t              status;
		logic [POS_W-1:0]     pos;
		logic [SCORE_W-1:0]   score;
	} result_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_QUERY
	} ctrl_state_t;

endpackage

`default_nettype wire

// File: rtl/sioc_ram.sv
// ----------------------------------------------------------------------------
// Sorted interval overlap count RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module sioc_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 32,
	parameter int AW    = 12
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/sioc_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted interval overlap count sequencer
// Runs the cursor walk, loads, queries and score clearing over the two tables.
// ----------------------------------------------------------------------------
`default_nettype none

module sioc_ctrl
	import sioc_pkg::*;
#(
	parameter int MAX_PEAKS  = DEF_MAX_PEAKS,
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int CHROM_BITS = DEF_CHROM_BITS,
	parameter int AW         = 12,
	parameter int PW         = CHROM_BITS + 2 * COORD_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Accepted input beat.
	input  wire logic                  start,
	input  wire op_t                   op,
	input  wire logic [CHROM_BITS-1:0] chrom,
	input  wire logic [COORD_BITS-1:0] istart,
	input  wire logic [COORD_BITS-1:0] iend,
	input  wire logic [SLOT_W-1:0]     slot,
	input  wire logic [CNT_W-1:0]      peak_count,
	output logic                       idle,
	// Result toward the output register.
	output logic                       res_valid,
	output result_t                    res,
	// Peak table ports.
	output logic                       pk_we,
	output logic [AW-1:0]              pk_waddr,
	output logic [PW-1:0]              pk_wdata,
	output logic [AW-1:0]              pk_raddr,
	input  wire logic [PW-1:0]         pk_rdata,
	// Score table ports.
	output logic                       sc_we,
	output logic [AW-1:0]              sc_waddr,
	output logic [SCORE_W-1:0]         sc_wdata,
	output logic [AW-1:0]              sc_raddr,
	input  wire logic [SCORE_W-1:0]    sc_rdata
);

	// Cursor runs from 0 to MAX_PEAKS inclusive; limits compare in LW bits.
	localparam int CW = $clog2(MAX_PEAKS + 1);
	localparam int LW = (CW > CNT_W) ? CW : CNT_W;
	localparam int SW = 17;

	ctrl_state_t state_q, state_d;

	logic [CW-1:0]         cursor_q;
	logic [AW-1:0]         clr_cnt_q;
	logic                  clr_reply_q;
	logic [LW-1:0]         lim_q;
	logic [CHROM_BITS-1:0] chrom_q;
	logic [COORD_BITS-1:0] rstart_q;
	logic [COORD_BITS-1:0] rend_q;
	logic [SLOT_W-1:0]     slot_q;

	logic [LW-1:0]         lim_d;
	logic                  slot_ok;
	logic                  sweep_done;
	logic                  clr_last;
	logic [CW-1:0]         cur_nx;
	logic                  nx_end;
	logic [CHROM_BITS-1:0] pk_chrom;
	logic [COORD_BITS-1:0] pk_start;
	logic [COORD_BITS-1:0] pk_end;
	logic                  same_chrom;
	logic                  overlap;
	logic                  advance;
	logic [SCORE_W-1:0]    score_inc;

	// Effective table size and start-of-read checks.
	assign lim_d      = (LW'(peak_count) > LW'(MAX_PEAKS)) ? LW'(MAX_PEAKS) : LW'(peak_count);
	assign slot_ok    = SW'(slot) < SW'(MAX_PEAKS);
	assign sweep_done = LW'(cursor_q) >= lim_d;
	assign clr_last   = clr_cnt_q == AW'(MAX_PEAKS - 1);

	// Compare unit on the peak under the cursor.
	assign pk_chrom   = pk_rdata[CHROM_BITS-1:0];
	assign pk_start   = pk_rdata[CHROM_BITS +: COORD_BITS];
	assign pk_end     = pk_rdata[CHROM_BITS+COORD_BITS +: COORD_BITS];
	assign same_chrom = pk_chrom == chrom_q;
	assign overlap    = same_chrom && (rstart_q <= pk_end) && (pk_start <= rend_q);
	assign advance    = (pk_chrom < chrom_q) || (same_chrom && !overlap && (rstart_q > pk_end));
	assign cur_nx     = cursor_q + CW'(1);
	assign nx_end     = LW'(cur_nx) >= lim_q;
	assign score_inc  = (sc_rdata == '1) ? sc_rdata : sc_rdata + SCORE_W'(1);

	assign idle = state_q == S_IDLE;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					unique case (op)
						OP_READ:    state_d = sweep_done ? S_IDLE : S_WALK;
						OP_QUERY:   state_d = slot_ok ? S_QUERY : S_IDLE;
						OP_RESTART: state_d = S_CLEAR;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_WALK: begin
				if (overlap || !advance || nx_end) begin
					state_d = S_IDLE;
				end
			end
			S_QUERY: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs: memory controls and the result.
	always_comb begin
		res_valid  = 1'b0;
		res.status = STAT_LOADED;
		res.pos    = '0;
		res.score  = '0;
		pk_we      = 1'b0;
		pk_waddr   = AW'(slot);
		pk_wdata   = {iend, istart, chrom};
		pk_raddr   = cursor_q[AW-1:0];
		sc_we      = 1'b0;
		sc_waddr   = cursor_q[AW-1:0];
		sc_wdata   = score_inc;
		sc_raddr   = cursor_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				sc_we     = 1'b1;
				sc_waddr  = clr_cnt_q;
				sc_wdata  = '0;
				res_valid = clr_last && clr_reply_q;
			end
			S_IDLE: begin
				if (start) begin
					unique case (op)
						OP_LOAD: begin
							pk_we     = slot_ok;
							res_valid = 1'b1;
							res.pos   = POS_W'(slot);
						end
						OP_READ: begin
							res_valid  = sweep_done;
							res.status = STAT_DONE;
							res.pos    = POS_W'(cursor_q);
						end
						OP_QUERY: begin
							sc_raddr   = AW'(slot);
							res_valid  = !slot_ok;
							res.status = STAT_SCORE;
							res.pos    = POS_W'(slot);
						end
						default: begin
						end
					endcase
				end
			end
			S_WALK: begin
				pk_raddr = cur_nx[AW-1:0];
				sc_raddr = cur_nx[AW-1:0];
				if (overlap) begin
					sc_we      = 1'b1;
					res_valid  = 1'b1;
					res.status = STAT_COUNTED;
					res.pos    = POS_W'(cursor_q);
				end else if (advance) begin
					res_valid  = nx_end;
					res.status = STAT_MISSED;
					res.pos    = POS_W'(cur_nx);
				end else begin
					res_valid  = 1'b1;
					res.status = STAT_MISSED;
					res.pos    = POS_W'(cursor_q);
				end
			end
			S_QUERY: begin
				res_valid  = 1'b1;
				res.status = STAT_SCORE;
				res.pos    = POS_W'(slot_q);
				res.score  = sc_rdata;
			end
			default: begin
			end
		endcase
	end

	// Control state: reset starts a clearing pass over the score table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cursor_q    <= '0;
			clr_cnt_q   <= '0;
			clr_reply_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_last) begin
					clr_reply_q <= 1'b0;
				end
			end
			if (state_q == S_IDLE && start && op == OP_RESTART) begin
				cursor_q    <= '0;
				clr_cnt_q   <= '0;
				clr_reply_q <= 1'b1;
			end
			if (state_q == S_WALK && !overlap && advance) begin
				cursor_q <= cur_nx;
			end
		end
	end

	// Operands of the current item.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			lim_q    <= lim_d;
			chrom_q  <= chrom;
			rstart_q <= istart;
			rend_q   <= iend;
			slot_q   <= slot;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sorted_interval_overlap_count_core.sv
// A load, or a read after the sweep end, is answered from its input beat. A query
// reads the score table first, and a read first walks the cursor over skipped peaks.
// Throughput: one item at a time; the cursor walk examines one peak per cycle, and
// a restart runs a clearing pass over the score table before the next item.
// Reset starts a clearing pass over the score table with s_tready low;
// configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
// Sorted interval overlap count core
// Counts sorted reads against a sorted peak table with a forward-only cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_interval_overlap_count_core
	import sioc_pkg::*;
#(
	parameter int MAX_PEAKS  = DEF_MAX_PEAKS,
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int CHROM_BITS = DEF_CHROM_BITS,
	parameter int IN_W       = ((CHROM_BITS + 2 * COORD_BITS + SLOT_W + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Input stream.
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// chrom_code, interval_start, interval_end, peak_slot, zero pad
	input  wire logic [IN_W-1:0]   s_tdata,
	// opcode
	input  wire logic [OP_W-1:0]   s_tuser,
	// Result stream.
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// peak_position, score_value, zero pad
	output logic [OUT_W-1:0]       m_tdata,
	// status
	output logic [STAT_W-1:0]      m_tuser,
	// Configuration port.
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int AW       = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
	localparam int PW       = CHROM_BITS + 2 * COORD_BITS;
	localparam int OFF_S    = CHROM_BITS;
	localparam int OFF_E    = CHROM_BITS + COORD_BITS;
	localparam int OFF_SLOT = CHROM_BITS + 2 * COORD_BITS;

	logic [CNT_W-1:0]   peak_count_q;
	logic               m_tvalid_q;
	result_t            m_res_q;
	logic               accept;
	logic               idle;
	logic               res_valid;
	result_t            res;
	logic               pk_we;
	logic [AW-1:0]      pk_waddr;
	logic [PW-1:0]      pk_wdata;
	logic [AW-1:0]      pk_raddr;
	logic [PW-1:0]      pk_rdata;
	logic               sc_we;
	logic [AW-1:0]      sc_waddr;
	logic [SCORE_W-1:0] sc_wdata;
	logic [AW-1:0]      sc_raddr;
	logic [SCORE_W-1:0] sc_rdata;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PEAK_COUNT) ? APB_DW'(peak_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_count_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PEAK_COUNT) begin
			peak_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// Input handshake: one item at a time, with room in the output register.
	assign s_tready = idle && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// Sequencer and compare unit.
	sioc_ctrl #(
		.MAX_PEAKS  (MAX_PEAKS),
		.COORD_BITS (COORD_BITS),
		.CHROM_BITS (CHROM_BITS),
		.AW         (AW),
		.PW         (PW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.op         (op_t'(s_tuser)),
		.chrom      (s_tdata[CHROM_BITS-1:0]),
		.istart     (s_tdata[OFF_S +: COORD_BITS]),
		.iend       (s_tdata[OFF_E +: COORD_BITS]),
		.slot       (s_tdata[OFF_SLOT +: SLOT_W]),
		.peak_count (peak_count_q),
		.idle       (idle),
		.res_valid  (res_valid),
		.res        (res),
		.pk_we      (pk_we),
		.pk_waddr   (pk_waddr),
		.pk_wdata   (pk_wdata),
		.pk_raddr   (pk_raddr),
		.pk_rdata   (pk_rdata),
		.sc_we      (sc_we),
		.sc_waddr   (sc_waddr),
		.sc_wdata   (sc_wdata),
		.sc_raddr   (sc_raddr),
		.sc_rdata   (sc_rdata)
	);

	// Peak table: chromosome, start and end of each peak.
	sioc_ram #(
		.DEPTH (MAX_PEAKS),
		.WIDTH (PW),
		.AW    (AW)
	) u_peak_ram (
		.clk   (clk),
		.we    (pk_we),
		.waddr (pk_waddr),
		.wdata (pk_wdata),
		.raddr (pk_raddr),
		.rdata (pk_rdata)
	);

	// Score table.
	sioc_ram #(
		.DEPTH (MAX_PEAKS),
		.WIDTH (SCORE_W),
		.AW    (AW)
	) u_score_ram (
		.clk   (clk),
		.we    (sc_we),
		.waddr (sc_waddr),
		.wdata (sc_wdata),
		.raddr (sc_raddr),
		.rdata (sc_rdata)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({m_res_q.score, m_res_q.pos});
	assign m_tuser  = m_res_q.status;

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted interval overlap count testbench
// Loads sorted peak tables of several sizes, streams reads, queries and
// restarts through the core, and checks every result beat in order against
// a cycle-free model of the forward-only sweep kept in a small scoreboard.
// ----------------------------------------------------------------------------

module testbench;
	import sioc_pkg::*;

	localparam int IN_W = ((DEF_CHROM_BITS + 2 * DEF_COORD_BITS + SLOT_W + 7) / 8) * 8;
	localparam int NPEAK = DEF_MAX_PEAKS;

	typedef logic [DEF_CHROM_BITS-1:0] chrom_t;
	typedef logic [DEF_COORD_BITS-1:0] coord_t;
	typedef logic [SLOT_W-1:0]         slot_t;

	// Sweep predictor and queue of expected result beats.
	class sweep_scoreboard;
		chrom_t            tbl_chrom [NPEAK];
		coord_t            tbl_lo [NPEAK];
		coord_t            tbl_hi [NPEAK];
		logic [SCORE_W-1:0] hits [NPEAK];
		int unsigned       cursor;
		logic [CNT_W-1:0]  table_size;
		result_t           expected_q [$];
		int                errors;
		int                checked;
		int                op_seen [4];
		int                status_seen [8];

		function new();
			foreach (hits[i]) hits[i] = '0;
			foreach (op_seen[i]) op_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			cursor = 0;
			table_size = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_table_size(logic [CNT_W-1:0] n);
			table_size = n;
		endfunction

		// A register value past the table depth sweeps the whole table.
		function int unsigned used_peaks();
			return (table_size > NPEAK) ? NPEAK : int'(table_size);
		endfunction

		// Walk the cursor for one read; at most one peak is scored.
		function status_t walk_read(chrom_t chrom, coord_t rs, coord_t re);
			int unsigned lim;
			lim = used_peaks();
			if (cursor >= lim)
				return STAT_DONE;
			while (cursor < lim) begin
				if (tbl_chrom[cursor] > chrom) begin
					return STAT_MISSED;
				end else if (tbl_chrom[cursor] < chrom) begin
					cursor++;
				end else if (rs <= tbl_hi[cursor] && tbl_lo[cursor] <= re) begin
					if (hits[cursor] != '1)
						hits[cursor] = hits[cursor] + 1'b1;
					return STAT_COUNTED;
				end else if (rs > tbl_hi[cursor]) begin
					cursor++;
				end else begin
					return STAT_MISSED;
				end
			end
			// Ran off the end of the table.
			return STAT_MISSED;
		endfunction

		// Every accepted input beat yields exactly one result beat.
		function void note_item(op_t op, chrom_t chrom, coord_t lo, coord_t hi, slot_t slot);
			result_t r;
			r.status = STAT_LOADED;
			r.pos = '0;
			r.score = '0;
			op_seen[int'(op)]++;
			// Slots are 12 bits wide, so every slot lies inside the table.
			case (op)
				OP_LOAD: begin
					tbl_chrom[slot] = chrom;
					tbl_lo[slot] = lo;
					tbl_hi[slot] = hi;
					r.pos = POS_W'(slot);
				end
				OP_READ: begin
					r.status = walk_read(chrom, lo, hi);
					r.pos = POS_W'(cursor);
				end
				OP_QUERY: begin
					r.status = STAT_SCORE;
					r.pos = POS_W'(slot);
					r.score = hits[slot];
				end
				default: begin
					foreach (hits[i]) hits[i] = '0;
					cursor = 0;
				end
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: status %0d pos %0d score %0d",
						got.status, got.pos, got.score);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.status !== want.status || got.pos !== want.pos ||
					got.score !== want.score) begin
				errors++;
				if (errors <= 10)
					$display("result mismatch: status %0d/%0d pos %0d/%0d score %0d/%0d (exp/got)",
						want.status, got.status, want.pos, got.pos, want.score, got.score);
			end else begin
				status_seen[int'(want.status)]++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic [OP_W-1:0]   s_tuser = OP_LOAD;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic [STAT_W-1:0] m_tuser;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	sweep_scoreboard board = new();

	// While set, neither side of the stream idles.
	bit quiet = 1'b0;

	// Sorted peaks of the current phase, used to aim the reads.
	chrom_t      guide_chrom [NPEAK];
	coord_t      guide_lo [NPEAK];
	coord_t      guide_hi [NPEAK];
	int unsigned aim;
	int unsigned random_items = 0;
	int unsigned sizes_used = 0;

	sorted_interval_overlap_count_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Generous bound on the whole run.
	initial begin
		#40_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	// Result side backpressure.
	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(0, 99) >= 32);
	end

	// Check every accepted result beat.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = status_t'(m_tuser);
			got.pos = m_tdata[POS_W-1:0];
			got.score = m_tdata[POS_W +: SCORE_W];
			board.check_result(got);
		end
	end

	// Offer one input beat, with a random gap first, and note it once taken.
	task automatic send_item(input op_t op, input chrom_t chrom, input coord_t lo,
			input coord_t hi, input slot_t slot);
		while (!quiet && $urandom_range(0, 99) < 32) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_W'({slot, hi, lo, chrom});
		do @(posedge clk); while (!s_tready);
		board.note_item(op, chrom, lo, hi, slot);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Write the table size once the core has nothing in flight.
	task automatic set_table_size(input logic [CNT_W-1:0] n);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(4 * int'(REG_PEAK_COUNT));
		pwdata <= APB_DW'(n);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_table_size(n);
		sizes_used++;
	endtask

	// Load slots 0..n-1 with peaks sorted by chromosome, then position.
	task automatic load_sorted_peaks(input int unsigned n);
		chrom_t      c;
		coord_t      at;
		coord_t      lo;
		int unsigned len;
		c = chrom_t'($urandom_range(0, 40));
		at = $urandom_range(0, 32'hF000_0000);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				c = (c < 1020) ? c + chrom_t'($urandom_range(1, 3)) : chrom_t'(1023);
				at = $urandom_range(0, 32'hF000_0000);
			end
			len = $urandom_range(0, 400);
			lo = at + $urandom_range(0, 600);
			guide_chrom[i] = c;
			guide_lo[i] = lo;
			guide_hi[i] = lo + len;
			// Now and then the next peak overlaps this one.
			at = ($urandom_range(0, 7) == 0) ? lo + len / 2 : lo + len + 1;
			send_item(OP_LOAD, c, guide_lo[i], guide_hi[i], slot_t'(i));
		end
	endtask

	// A read placed around the peak the sweep is expected to reach next.
	task automatic send_guided_read(input int unsigned n, input int unsigned jump);
		int unsigned t;
		coord_t      span;
		coord_t      lo;
		coord_t      hi;
		chrom_t      c;
		if ($urandom_range(0, 3) == 0)
			aim += $urandom_range(1, jump);
		if (aim >= n) begin
			// Past every peak: the walk stops at the fence or at the end of the table.
			send_item(OP_READ, '1, '1, '1, slot_t'($urandom()));
			return;
		end
		t = aim;
		c = guide_chrom[t];
		span = guide_hi[t] - guide_lo[t];
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				lo = guide_lo[t] + $urandom_range(0, span);
				hi = lo + $urandom_range(0, 40);
			end
			6: begin
				lo = guide_lo[t] - $urandom_range(1, 30);
				hi = guide_lo[t] - 1;
			end
			7: begin
				lo = guide_hi[t] + 1;
				hi = lo + $urandom_range(0, 10);
			end
			8: begin
				// Reversed interval.
				lo = guide_hi[t];
				hi = guide_lo[t];
			end
			default: begin
				// Earlier chromosome than the peak.
				c = (c != 0) ? c - 1'b1 : c;
				lo = $urandom();
				hi = $urandom();
			end
		endcase
		send_item(OP_READ, c, lo, hi, slot_t'($urandom()));
	endtask

	// One table setting: restart, optional reload, mixed traffic, two closing reads.
	// With fewer peaks than the table size, a fence peak right after them stops
	// every walk, so the sweep never reaches slots that were not loaded.
	task automatic run_phase(input int unsigned size, input int unsigned peaks,
			input bit reload, input int unsigned jump, input int unsigned items);
		int unsigned n;
		int unsigned pick;
		bit          fenced;
		n = (size > NPEAK) ? NPEAK : size;
		fenced = peaks < n;
		if (fenced)
			n = peaks;
		set_table_size(CNT_W'(size));
		send_item(OP_RESTART, chrom_t'($urandom()), $urandom(), $urandom(), slot_t'($urandom()));
		aim = 0;
		if (reload) begin
			load_sorted_peaks(n);
			if (fenced)
				send_item(OP_LOAD, '1, '1, '1, slot_t'(n));
		end
		for (int unsigned i = 0; i < items; i++) begin
			if ($urandom_range(0, 39) == 0)
				wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 74) begin
				send_guided_read(n, jump);
			end else if (pick < 84) begin
				send_item(OP_QUERY, chrom_t'($urandom()), $urandom(), $urandom(),
					($urandom_range(0, 1) == 0) ? slot_t'($urandom_range(0, n + 2))
						: slot_t'($urandom()));
			end else if (pick < 92) begin
				// The fence and the peaks before it stay in place.
				send_item(OP_LOAD, chrom_t'($urandom()), $urandom(), $urandom(),
					fenced ? slot_t'($urandom_range(n + 1, NPEAK - 1))
						: slot_t'($urandom()));
			end else if (pick < 98) begin
				send_item(OP_READ, chrom_t'($urandom()), $urandom(), $urandom(),
					slot_t'($urandom()));
			end else begin
				send_item(OP_RESTART, chrom_t'($urandom()), $urandom(), $urandom(),
					slot_t'($urandom()));
				aim = 0;
			end
			random_items++;
		end
		aim = n;
		send_guided_read(n, jump);
		send_guided_read(n, jump);
	endtask

	initial begin
		int unsigned phase_no;
		int unsigned size_pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Empty table: the sweep is finished from the start.
		set_table_size('0);
		send_item(OP_READ, 10'd3, 32'd0, 32'd10, 12'd0);
		send_item(OP_QUERY, 10'd0, 32'd0, 32'd0, 12'hFFF);

		// Small hand-built table.
		send_item(OP_LOAD, 10'd2, 32'd100, 32'd200, 12'd0);
		send_item(OP_LOAD, 10'd2, 32'd300, 32'd400, 12'd1);
		send_item(OP_LOAD, 10'd5, 32'd0, 32'd50, 12'd2);
		send_item(OP_LOAD, 10'd5, 32'd1000, 32'hFFFF_FFFF, 12'd3);
		send_item(OP_LOAD, 10'd1023, 32'd10, 32'd20, 12'd4);
		send_item(OP_LOAD, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
		set_table_size(13'd5);

		// Earlier chromosome, plain and reversed overlaps, a peak after the read,
		// skips past ends and chromosomes, table exhaustion and a finished sweep.
		send_item(OP_READ, 10'd1, 32'd0, 32'd10, 12'd0);
		send_item(OP_READ, 10'd2, 32'd150, 32'd150, 12'd0);
		send_item(OP_READ, 10'd2, 32'd200, 32'd100, 12'd0);
		send_item(OP_READ, 10'd2, 32'd250, 32'd260, 12'd0);
		send_item(OP_READ, 10'd2, 32'd400, 32'd400, 12'd0);
		send_item(OP_READ, 10'd5, 32'd60, 32'd70, 12'd0);
		send_item(OP_READ, 10'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd0);
		send_item(OP_READ, 10'd1023, 32'd15, 32'd15, 12'd0);
		send_item(OP_READ, 10'd1023, 32'd20, 32'd10, 12'd0);
		send_item(OP_READ, 10'd1023, 32'd30, 32'd40, 12'd0);
		send_item(OP_READ, 10'd1023, 32'd0, 32'hFFFF_FFFF, 12'd0);
		send_item(OP_QUERY, 10'd0, 32'd0, 32'd0, 12'd0);
		send_item(OP_QUERY, 10'd0, 32'd0, 32'd0, 12'd4);
		send_item(OP_QUERY, 10'd0, 32'd0, 32'd0, 12'hFFF);
		send_item(OP_RESTART, 10'd0, 32'd0, 32'd0, 12'd0);
		send_item(OP_QUERY, 10'd0, 32'd0, 32'd0, 12'd0);

		// Random part: one peak, the full table size and a size past the table,
		// both fenced after 40 peaks, then many small tables, one of them with
		// no idling on either side.
		run_phase(1, 1, 1'b1, 2, 30);
		run_phase(NPEAK, 40, 1'b1, 4, 80);
		run_phase(8191, 40, 1'b0, 4, 40);
		phase_no = 0;
		while (random_items < 360) begin
			quiet = (phase_no == 2);
			size_pick = $urandom_range(2, 40);
			run_phase(size_pick, size_pick, 1'b1, 2, $urandom_range(25, 60));
			phase_no++;
		end
		quiet = 1'b0;

		wait_drained();
		repeat (50) @(posedge clk);
		board.errors += board.expected_q.size();

		$display("Sent %0d loads, %0d reads, %0d queries, %0d restarts over %0d table sizes.",
			board.op_seen[OP_LOAD], board.op_seen[OP_READ], board.op_seen[OP_QUERY],
			board.op_seen[OP_RESTART], sizes_used);
		$display("Checked %0d results: %0d reads counted, %0d missed, %0d after sweep end.",
			board.checked, board.status_seen[STAT_COUNTED], board.status_seen[STAT_MISSED],
			board.status_seen[STAT_DONE]);
		if (board.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
